>>> rtl/gbn_pkg.sv
// Shared constants, codes, types and slot arithmetic of the go-back-N sender window.
package gbn_pkg;

   // Window and field sizes
   localparam int MAX_WINDOW    = 8;
   localparam int SLOT_BITS     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int SEQ_BITS      = 16;
   localparam int TIME_BITS     = 16;
   localparam int PAY_BITS      = 32;
   localparam int TMO_BITS      = 8;
   localparam int LIM_BITS      = 4;
   localparam int CNT_BITS      = $clog2(MAX_WINDOW + 1);
   localparam int MODE_BITS     = 2;
   localparam int KIND_BITS     = 3;
   localparam int CSR_IDX_BITS  = 1;
   localparam int CSR_DATA_BITS = 8;
   localparam int REQ_DATA_BITS = 48;
   localparam int RSP_DATA_BITS = 80;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = 1;
   localparam int QCNT_BITS   = 2;

   // Input mode codes
   localparam logic [MODE_BITS-1:0] MODE_SEND = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_ACK  = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_TICK = 2'd2;

   // Result kind codes
   localparam logic [KIND_BITS-1:0] KIND_SENT      = 3'd0;
   localparam logic [KIND_BITS-1:0] KIND_REFUSED   = 3'd1;
   localparam logic [KIND_BITS-1:0] KIND_ACK_TAKEN = 3'd2;
   localparam logic [KIND_BITS-1:0] KIND_ACK_STALE = 3'd3;
   localparam logic [KIND_BITS-1:0] KIND_RETX      = 3'd4;
   localparam logic [KIND_BITS-1:0] KIND_TICK_IDLE = 3'd5;

   // Register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_TIMEOUT = 1'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LIMIT   = 1'd1;

   // Reset values of the registers
   localparam logic [TMO_BITS-1:0] TIMEOUT_RESET = 8'd3;
   localparam logic [LIM_BITS-1:0] LIMIT_RESET   = 4'd5;

   // Classified operation
   typedef enum logic [1:0] {
      OP_SEND = 2'd0,
      OP_ACK  = 2'd1,
      OP_TICK = 2'd2
   } op_type;

   // One queued command
   typedef struct packed {
      op_type                op;
      logic [PAY_BITS-1:0]   payload;
      logic [SEQ_BITS-1:0]   ack;
   } cmd_type;

   // Slot of window position k: (head + k) mod MAX_WINDOW, k at most MAX_WINDOW
   function automatic logic [SLOT_BITS-1:0] slot_add(input logic [SLOT_BITS-1:0] head,
                                                    input logic [SLOT_BITS:0]   k);
      logic [SLOT_BITS+1:0] sum;
      sum = {2'b00, head} + {1'b0, k};
      if (sum >= (SLOT_BITS + 2)'(MAX_WINDOW)) begin
         sum = sum - (SLOT_BITS + 2)'(MAX_WINDOW);
      end
      return sum[SLOT_BITS-1:0];
   endfunction

   // Window position of a physical slot: (slot - head) mod MAX_WINDOW
   function automatic logic [SLOT_BITS-1:0] slot_dist(input logic [SLOT_BITS-1:0] slot,
                                                     input logic [SLOT_BITS-1:0] head);
      logic [SLOT_BITS+1:0] diff;
      diff = {2'b00, slot} + (SLOT_BITS + 2)'(MAX_WINDOW) - {2'b00, head};
      if (diff >= (SLOT_BITS + 2)'(MAX_WINDOW)) begin
         diff = diff - (SLOT_BITS + 2)'(MAX_WINDOW);
      end
      return diff[SLOT_BITS-1:0];
   endfunction

endpackage

>>> rtl/gbn_front.sv
// Front end: accepts request beats, classifies them and queues commands for the back end.
module gbn_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // payload [31:0], ack_number [47:32]
   input  logic [gbn_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // mode [1:0]
   input  logic [gbn_pkg::MODE_BITS-1:0]     req_tuser,
   output logic                              cmd_valid,
   output gbn_pkg::cmd_type                  cmd,
   input  logic                              cmd_pop
);
   import gbn_pkg::*;

   cmd_type              queue_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;
   logic                 accept;
   logic                 push;
   logic                 known;
   cmd_type              cmd_new;

   // Classify the incoming beat; the unused mode is dropped
   always_comb begin
      known           = 1'b1;
      cmd_new.op      = OP_SEND;
      cmd_new.payload = req_tdata[PAY_BITS-1:0];
      cmd_new.ack     = req_tdata[PAY_BITS +: SEQ_BITS];
      case (req_tuser)
         MODE_SEND: cmd_new.op = OP_SEND;
         MODE_ACK:  cmd_new.op = OP_ACK;
         MODE_TICK: cmd_new.op = OP_TICK;
         default:   known = 1'b0;
      endcase
   end

   assign req_tready = (count_ff < QCNT_BITS'(QUEUE_DEPTH));
   assign accept     = req_tvalid && req_tready;
   assign push       = accept && known;
   assign cmd_valid  = (count_ff != '0);
   assign cmd        = queue_ff[rd_ptr_ff];

   // Advance queue pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (cmd_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !cmd_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && cmd_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the command
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cmd_new;
      end
   end

   // Fill count never passes the depth
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_BITS'(QUEUE_DEPTH))
      else $error("command queue overfilled");

   // A pop of the only entry without a push empties the queue
   assert property (@(posedge clock) disable iff (reset)
      (count_ff == QCNT_BITS'(1)) && cmd_pop && !push |=> (count_ff == '0))
      else $error("command queue count out of step");

endmodule

>>> rtl/gbn_back.sv
// Back end: window state, slot store, retransmit scan and the result register.
module gbn_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [gbn_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [gbn_pkg::CSR_DATA_BITS-1:0] csr_wdata,
   input  logic                              cmd_valid,
   input  gbn_pkg::cmd_type                  cmd,
   output logic                              cmd_pop,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // seq_number [15:0], packet_payload [47:16], window_base [63:48], window_next [79:64]
   output logic [gbn_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   // kind [2:0]
   output logic [gbn_pkg::KIND_BITS-1:0]     rsp_tuser,
   output logic                              rsp_tlast
);
   import gbn_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   // Configuration
   logic [TMO_BITS-1:0]  timeout_ff;
   logic [LIM_BITS-1:0]  limit_ff;

   // Window state
   state_type            state_ff, state_in;
   logic [SEQ_BITS-1:0]  base_ff, base_in;
   logic [SEQ_BITS-1:0]  next_ff, next_in;
   logic [TIME_BITS-1:0] now_ff, now_in;
   logic [SLOT_BITS-1:0] head_ff, head_in;
   logic [MAX_WINDOW-1:0] mask_ff, mask_in;
   logic [PAY_BITS-1:0]  slot_pay_ff  [MAX_WINDOW];
   logic [TIME_BITS-1:0] slot_time_ff [MAX_WINDOW];

   // Result register
   logic                 out_valid_ff, out_valid_in;
   logic [KIND_BITS-1:0] out_kind_ff, out_kind_in;
   logic [SEQ_BITS-1:0]  out_seq_ff, out_seq_in;
   logic [PAY_BITS-1:0]  out_pay_ff, out_pay_in;
   logic [SEQ_BITS-1:0]  out_base_ff, out_base_in;
   logic [SEQ_BITS-1:0]  out_next_ff, out_next_in;
   logic                 out_last_ff, out_last_in;
   logic                 out_load;
   logic                 out_free;

   // Working signals
   logic [SEQ_BITS-1:0]   n_full;
   logic [SLOT_BITS:0]    n_k;
   logic [CNT_BITS-1:0]   eff_limit;
   logic                  win_full;
   logic [SEQ_BITS-1:0]   ack_dist;
   logic                  ack_ok;
   logic [SLOT_BITS-1:0]  send_slot;
   logic [MAX_WINDOW-1:0] due_phys;
   logic [MAX_WINDOW-1:0] due_k;
   logic [MAX_WINDOW-1:0] mask_rest;
   logic [SLOT_BITS-1:0]  k_sel;
   logic [SLOT_BITS-1:0]  s_sel;
   logic                  pay_we;
   logic [SLOT_BITS-1:0]  pay_slot;
   logic                  time_all;
   logic                  time_we;
   logic [SLOT_BITS-1:0]  time_slot;

   // Take register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
         limit_ff   <= LIMIT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TIMEOUT: timeout_ff <= csr_wdata[TMO_BITS-1:0];
            CSR_LIMIT:   limit_ff   <= csr_wdata[LIM_BITS-1:0];
            default:     ;
         endcase
      end
   end

   // Window occupancy and limit
   assign n_full   = next_ff - base_ff;
   assign n_k      = n_full[SLOT_BITS:0];
   always_comb begin
      if (limit_ff == '0) begin
         eff_limit = CNT_BITS'(1);
      end else if (int'(limit_ff) > MAX_WINDOW) begin
         eff_limit = CNT_BITS'(MAX_WINDOW);
      end else begin
         eff_limit = CNT_BITS'(limit_ff);
      end
   end
   assign win_full  = (n_full >= SEQ_BITS'(eff_limit));
   assign send_slot = slot_add(head_ff, n_k);
   assign ack_dist  = cmd.ack - base_ff;
   assign ack_ok    = (ack_dist != '0) && (ack_dist <= n_full);

   // Mark outstanding slots whose age passes the timeout, then order oldest first
   always_comb begin
      for (int i = 0; i < MAX_WINDOW; i++) begin
         due_phys[i] = (SEQ_BITS'(slot_dist(SLOT_BITS'(i), head_ff)) < n_full) &&
                       ((now_ff - slot_time_ff[i]) > TIME_BITS'(timeout_ff));
      end
      for (int k = 0; k < MAX_WINDOW; k++) begin
         due_k[k] = due_phys[slot_add(head_ff, (SLOT_BITS + 1)'(k))];
      end
   end

   // Pick the oldest due packet of the scan
   always_comb begin
      k_sel = '0;
      for (int k = MAX_WINDOW - 1; k >= 0; k--) begin
         if (mask_ff[k]) begin
            k_sel = SLOT_BITS'(k);
         end
      end
      mask_rest        = mask_ff;
      mask_rest[k_sel] = 1'b0;
   end
   assign s_sel = slot_add(head_ff, {1'b0, k_sel});

   assign out_free = !out_valid_ff || rsp_tready;

   // Sequence one command: sends, acks and idle ticks at once, ticks with due packets through the scan
   always_comb begin
      state_in    = state_ff;
      base_in     = base_ff;
      next_in     = next_ff;
      now_in      = now_ff;
      head_in     = head_ff;
      mask_in     = mask_ff;
      cmd_pop     = 1'b0;
      out_load    = 1'b0;
      out_kind_in = KIND_TICK_IDLE;
      out_seq_in  = '0;
      out_pay_in  = '0;
      out_last_in = 1'b1;
      pay_we      = 1'b0;
      pay_slot    = send_slot;
      time_all    = 1'b0;
      time_we     = 1'b0;
      time_slot   = send_slot;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_pop = 1'b1;
               case (cmd.op)
                  OP_SEND: begin
                     out_load = 1'b1;
                     if (win_full) begin
                        out_kind_in = KIND_REFUSED;
                     end else begin
                        pay_we      = 1'b1;
                        time_we     = 1'b1;
                        next_in     = next_ff + 1'b1;
                        out_kind_in = KIND_SENT;
                        out_seq_in  = next_ff;
                        out_pay_in  = cmd.payload;
                     end
                  end
                  OP_ACK: begin
                     out_load = 1'b1;
                     if (ack_ok) begin
                        base_in     = cmd.ack;
                        head_in     = slot_add(head_ff, ack_dist[SLOT_BITS:0]);
                        time_all    = 1'b1;
                        out_kind_in = KIND_ACK_TAKEN;
                     end else begin
                        out_kind_in = KIND_ACK_STALE;
                     end
                  end
                  OP_TICK: begin
                     if (due_k == '0) begin
                        out_load    = 1'b1;
                        out_kind_in = KIND_TICK_IDLE;
                        now_in      = now_ff + 1'b1;
                     end else begin
                        mask_in  = due_k;
                        state_in = ST_SCAN;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            if (out_free) begin
               out_load    = 1'b1;
               out_kind_in = KIND_RETX;
               out_seq_in  = base_ff + SEQ_BITS'(k_sel);
               out_pay_in  = slot_pay_ff[s_sel];
               out_last_in = (mask_rest == '0);
               time_we     = 1'b1;
               time_slot   = s_sel;
               mask_in     = mask_rest;
               if (mask_rest == '0) begin
                  now_in   = now_ff + 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
      out_base_in  = base_in;
      out_next_in  = next_in;
      out_valid_in = out_load ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         base_ff      <= '0;
         next_ff      <= '0;
         now_ff       <= '0;
         head_ff      <= '0;
         mask_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         next_ff      <= next_in;
         now_ff       <= now_in;
         head_ff      <= head_in;
         mask_ff      <= mask_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Load the result beat
   always_ff @(posedge clock) begin
      if (out_load) begin
         out_kind_ff <= out_kind_in;
         out_seq_ff  <= out_seq_in;
         out_pay_ff  <= out_pay_in;
         out_base_ff <= out_base_in;
         out_next_ff <= out_next_in;
         out_last_ff <= out_last_in;
      end
   end

   // Write the slot store; a taken ack restarts every timer
   always_ff @(posedge clock) begin
      if (pay_we) begin
         slot_pay_ff[pay_slot] <= cmd.payload;
      end
      for (int i = 0; i < MAX_WINDOW; i++) begin
         if (time_all || (time_we && (time_slot == SLOT_BITS'(i)))) begin
            slot_time_ff[i] <= now_ff;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_next_ff, out_base_ff, out_pay_ff, out_seq_ff};
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;

   // In-flight count stays within the window
   assert property (@(posedge clock) disable iff (reset)
      n_full <= SEQ_BITS'(MAX_WINDOW))
      else $error("window holds more packets than slots");

   // A scan always has a due packet left
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (mask_ff != '0))
      else $error("retransmit scan with empty mask");

   // Only the scan produces a result that is not the last of its item
   assert property (@(posedge clock) disable iff (reset)
      out_load && !out_last_in |-> (state_ff == ST_SCAN))
      else $error("non-final result outside a scan");

   // Time advances only with the final result of a tick
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && (now_ff != $past(now_ff)) |->
         $past(out_load && out_last_in &&
               ((out_kind_in == KIND_RETX) || (out_kind_in == KIND_TICK_IDLE))))
      else $error("tick counter moved without a finished tick");

endmodule

>>> rtl/go_back_n_sender_window_unit.sv
// Top level of the go-back-N sender window: front end, command queue and back end.
// A send or ack is held in the command queue, then gives its result beat from the result
// register; a tick first marks due slots, then the retransmit scan gives one beat per
// retransmitted packet, oldest first, through the single slot read port; the back end
// takes no new command during the scan, and a 2-entry queue decouples input.
// Reset: synchronous; clears window base, next, time, queue and result valid flag;
// registers return to timeout 3 and window limit 5; slot contents stay undefined.
module go_back_n_sender_window_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [gbn_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [gbn_pkg::CSR_DATA_BITS-1:0] csr_wdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // payload [31:0], ack_number [47:32]
   input  logic [gbn_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // mode [1:0]
   input  logic [gbn_pkg::MODE_BITS-1:0]     req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // seq_number [15:0], packet_payload [47:16], window_base [63:48], window_next [79:64]
   output logic [gbn_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   // kind [2:0]
   output logic [gbn_pkg::KIND_BITS-1:0]     rsp_tuser,
   output logic                              rsp_tlast
);
   import gbn_pkg::*;

   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd;

   gbn_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop)
   );

   gbn_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> tb/go_back_n_sender_window_unit_tb.sv
// Self-checking testbench of the go-back-N sender window with a built-in window predictor.
`timescale 1ns / 1ps

module go_back_n_sender_window_unit_tb;
   import gbn_pkg::*;

   // Mode value the block must ignore
   localparam logic [MODE_BITS-1:0] MODE_NONE = 2'd3;

   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 20;
   localparam int CYCLE_LIMIT = 600000;
   localparam int REPORT_CAP = 60;

   // One request beat
   typedef struct packed {
      logic [MODE_BITS-1:0] mode;
      logic [PAY_BITS-1:0]  payload;
      logic [SEQ_BITS-1:0]  ack;
   } req_item_type;

   // One result beat
   typedef struct packed {
      logic [KIND_BITS-1:0] kind;
      logic [SEQ_BITS-1:0]  seq;
      logic [PAY_BITS-1:0]  pay;
      logic [SEQ_BITS-1:0]  base;
      logic [SEQ_BITS-1:0]  nxt;
      logic                 last;
   } rsp_item_type;

   // Window state and registers
   typedef struct packed {
      logic [TMO_BITS-1:0]                      timeout;
      logic [LIM_BITS-1:0]                      limit;
      logic [SEQ_BITS-1:0]                      base;
      logic [SEQ_BITS-1:0]                      nxt;
      logic [TIME_BITS-1:0]                     now;
      logic [SLOT_BITS-1:0]                     head;
      logic [MAX_WINDOW-1:0][PAY_BITS-1:0]      pay;
      logic [MAX_WINDOW-1:0][TIME_BITS-1:0]     stamp;
   } win_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     csr_we = 1'b0;
   logic [CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;
   logic [MODE_BITS-1:0]     req_tuser = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic [KIND_BITS-1:0]     rsp_tuser;
   logic                     rsp_tlast;

   go_back_n_sender_window_unit dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   req_item_type req_backlog[$];
   rsp_item_type want_beats[$];

   win_type   pred;
   win_type   gen;
   bit        req_gaps_on = 1'b1;
   bit        rsp_gaps_on = 1'b1;
   int        hold_token = 0;
   int        hold_seen = 0;
   int        hold_left = 0;
   int        req_gap = 0;
   int        rsp_gap = 0;
   int        err_count = 0;
   int        cycle_count = 0;
   int        items_taken = 0;
   int        beats_checked = 0;
   int        retx_count = 0;
   int        refused_count = 0;
   int        settings_run = 0;

   // Driver-side scratch
   req_item_type took;
   rsp_item_type step_out [MAX_WINDOW];
   int           step_cnt;
   // Monitor-side scratch
   rsp_item_type got;
   rsp_item_type want;

   function automatic win_type win_reset();
      win_type st;
      st = '0;
      st.timeout = TIMEOUT_RESET;
      st.limit   = LIMIT_RESET;
      return st;
   endfunction

   function automatic rsp_item_type make_beat(input logic [KIND_BITS-1:0] kind,
                                              input logic [SEQ_BITS-1:0] seq,
                                              input logic [PAY_BITS-1:0] pay,
                                              input win_type st);
      rsp_item_type b;
      b.kind = kind;
      b.seq  = seq;
      b.pay  = pay;
      b.base = st.base;
      b.nxt  = st.nxt;
      b.last = 1'b0;
      return b;
   endfunction

   // Advance the window by one request beat and list the result beats it causes
   task automatic win_advance(inout win_type st, input req_item_type it,
                              output rsp_item_type outs [MAX_WINDOW], output int cnt);
      int                   lim;
      int                   s;
      int                   i;
      logic [SEQ_BITS-1:0]  n;
      logic [SEQ_BITS-1:0]  ack_gap;
      logic [TIME_BITS-1:0] age;
      cnt = 0;
      for (i = 0; i < MAX_WINDOW; i++) outs[i] = '0;
      // out-of-range limits clamp to 1..MAX_WINDOW
      if (st.limit == 0) lim = 1;
      else if (int'(st.limit) > MAX_WINDOW) lim = MAX_WINDOW;
      else lim = int'(st.limit);
      n = st.nxt - st.base;
      case (it.mode)
         MODE_SEND: begin
            if (int'(n) >= lim) begin
               outs[0] = make_beat(KIND_REFUSED, '0, '0, st);
            end else begin
               s = (int'(st.head) + int'(n)) % MAX_WINDOW;
               st.pay[s]   = it.payload;
               st.stamp[s] = st.now;
               st.nxt      = st.nxt + 1'b1;
               outs[0] = make_beat(KIND_SENT, st.nxt - 1'b1, it.payload, st);
            end
            cnt = 1;
         end
         MODE_ACK: begin
            ack_gap = it.ack - st.base;
            if (ack_gap >= 1 && ack_gap <= n) begin
               st.base = it.ack;
               st.head = SLOT_BITS'((int'(st.head) + int'(ack_gap)) % MAX_WINDOW);
               n = st.nxt - st.base;
               // restart every outstanding timer
               for (i = 0; i < int'(n); i++) begin
                  st.stamp[(int'(st.head) + i) % MAX_WINDOW] = st.now;
               end
               outs[0] = make_beat(KIND_ACK_TAKEN, '0, '0, st);
            end else begin
               outs[0] = make_beat(KIND_ACK_STALE, '0, '0, st);
            end
            cnt = 1;
         end
         MODE_TICK: begin
            // scan oldest first, resend what has aged past the timeout
            for (i = 0; i < int'(n) && i < MAX_WINDOW; i++) begin
               s = (int'(st.head) + i) % MAX_WINDOW;
               age = st.now - st.stamp[s];
               if (age > TIME_BITS'(st.timeout)) begin
                  st.stamp[s] = st.now;
                  outs[cnt] = make_beat(KIND_RETX, st.base + SEQ_BITS'(i), st.pay[s], st);
                  cnt++;
               end
            end
            st.now = st.now + 1'b1;
            if (cnt == 0) begin
               outs[0] = make_beat(KIND_TICK_IDLE, '0, '0, st);
               cnt = 1;
            end
         end
         default: ;
      endcase
      if (cnt > 0) outs[cnt-1].last = 1'b1;
   endtask

   function automatic int pick_gap(input bit on);
      int r;
      if (!on) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic report(input string what, input logic [31:0] got_v, input logic [31:0] want_v);
      if (err_count < REPORT_CAP) begin
         $display("mismatch on %s: got %0h, want %0h (cycle %0d)", what, got_v, want_v,
                  cycle_count);
      end
      err_count++;
   endtask

   // Clock
   initial begin
      forever #5 clock = ~clock;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d beats still due", cycle_count,
                  want_beats.size());
         $display("go_back_n_sender_window_unit_tb: errors");
         $finish;
      end
   end

   // Request driver: present backlog beats, predict each accepted one
   always @(posedge clock) begin
      if (reset) begin
         pred = win_reset();
         req_gap = 0;
         req_tvalid <= 1'b0;
      end else begin
         // snoop register writes into the predictor
         if (csr_we) begin
            case (csr_index)
               CSR_TIMEOUT: pred.timeout = csr_wdata[TMO_BITS-1:0];
               CSR_LIMIT:   pred.limit   = csr_wdata[LIM_BITS-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            took = req_backlog.pop_front();
            win_advance(pred, took, step_out, step_cnt);
            for (int i = 0; i < step_cnt; i++) want_beats.push_back(step_out[i]);
            items_taken++;
            req_gap = pick_gap(req_gaps_on);
         end
         if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (req_backlog.size() != 0) begin
            req_tvalid <= 1'b1;
            req_tdata  <= {req_backlog[0].ack, req_backlog[0].payload};
            req_tuser  <= req_backlog[0].mode;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result monitor: compare each beat with the oldest prediction, pace tready
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.kind = rsp_tuser;
            got.seq  = rsp_tdata[15:0];
            got.pay  = rsp_tdata[47:16];
            got.base = rsp_tdata[63:48];
            got.nxt  = rsp_tdata[79:64];
            got.last = rsp_tlast;
            beats_checked++;
            if (got.kind == KIND_RETX) retx_count++;
            if (got.kind == KIND_REFUSED) refused_count++;
            if (want_beats.size() == 0) begin
               report("unexpected beat, kind", got.kind, '0);
            end else begin
               want = want_beats.pop_front();
               if (got.kind !== want.kind) report("kind", got.kind, want.kind);
               if (got.seq !== want.seq) report("seq_number", got.seq, want.seq);
               if (got.pay !== want.pay) report("packet_payload", got.pay, want.pay);
               if (got.base !== want.base) report("window_base", got.base, want.base);
               if (got.nxt !== want.nxt) report("window_next", got.nxt, want.nxt);
               if (got.last !== want.last) report("last", got.last, want.last);
            end
            rsp_gap = pick_gap(rsp_gaps_on);
         end
         // long hold-off on request, otherwise random gaps
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (hold_seen != hold_token) begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES - 1;
            rsp_tready <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Queue one request beat, tracking the window it will meet
   task automatic add_item(input logic [MODE_BITS-1:0] mode, input logic [PAY_BITS-1:0] pay,
                           input logic [SEQ_BITS-1:0] ack);
      req_item_type it;
      rsp_item_type scratch [MAX_WINDOW];
      int           cnt;
      it.mode    = mode;
      it.payload = pay;
      it.ack     = ack;
      win_advance(gen, it, scratch, cnt);
      req_backlog.push_back(it);
   endtask

   // Mostly well-formed traffic with a share of stale acks and ignored beats
   task automatic add_random(input int count);
      int                  r;
      int                  n;
      int                  done;
      logic [SEQ_BITS-1:0] junk_ack;
      logic [PAY_BITS-1:0] junk_pay;
      done = 0;
      while (done < count) begin
         r = $urandom_range(0, 99);
         n = int'(SEQ_BITS'(gen.nxt - gen.base));
         junk_ack = SEQ_BITS'($urandom);
         junk_pay = $urandom;
         done++;
         if (r < 40) begin
            add_item(MODE_SEND, junk_pay, junk_ack);
         end else if (r < 62) begin
            if (n > 0) add_item(MODE_ACK, junk_pay, gen.base + SEQ_BITS'($urandom_range(1, n)));
            else add_item(MODE_ACK, junk_pay, gen.base);
         end else if (r < 88) begin
            add_item(MODE_TICK, junk_pay, junk_ack);
         end else if (r < 91) begin
            add_item(MODE_ACK, junk_pay, gen.base);
         end else if (r < 95) begin
            add_item(MODE_ACK, junk_pay,
                     gen.base + SEQ_BITS'($urandom_range(n + 1, (1 << SEQ_BITS) - 1)));
         end else begin
            // ignored beat, not counted
            add_item(MODE_NONE, junk_pay, junk_ack);
            done--;
         end
      end
   endtask

   task automatic wait_idle();
      while (req_backlog.size() != 0 || want_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // Drain, then load both registers and resync the generator's window copy
   task automatic set_window(input int tmo, input int lim);
      wait_idle();
      csr_write(CSR_TIMEOUT, CSR_DATA_BITS'(tmo));
      csr_write(CSR_LIMIT, {4'($urandom_range(0, 15)), 4'(lim)});
      @(posedge clock);
      @(posedge clock);
      gen = pred;
      settings_run++;
   endtask

   task automatic random_phase(input int tmo, input int lim, input bit req_on, input bit rsp_on,
                               input int count, input bit long_hold);
      set_window(tmo, lim);
      req_gaps_on = req_on;
      rsp_gaps_on = rsp_on;
      if (long_hold) hold_token++;
      add_random(count);
   endtask

   // Stimulus
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      @(posedge clock);
      gen = pred;
      settings_run = 1;

      // Directed, reset registers: idle tick, fill, refuse, stale and taken acks,
      // ignored mode, timed-out resend, full drain
      add_item(MODE_TICK, '0, '0);
      add_item(MODE_SEND, 32'h0000_0000, 16'hFFFF);
      add_item(MODE_SEND, 32'hFFFF_FFFF, 16'h0000);
      add_item(MODE_SEND, 32'hA5A5_A5A5, 16'h5A5A);
      add_item(MODE_SEND, 32'h5A5A_5A5A, 16'hA5A5);
      add_item(MODE_SEND, 32'h0F0F_0F0F, 16'hF0F0);
      add_item(MODE_SEND, 32'h1234_5678, 16'h0001);
      add_item(MODE_ACK, 32'hFFFF_FFFF, gen.base);
      add_item(MODE_ACK, 32'h0, 16'hFFFF);
      add_item(MODE_ACK, 32'h0, gen.base + 16'd2);
      add_item(MODE_NONE, 32'hFFFF_FFFF, 16'hFFFF);
      repeat (5) add_item(MODE_TICK, 32'hFFFF_FFFF, 16'hFFFF);
      add_item(MODE_ACK, 32'h0, gen.nxt);

      // Directed: wide window, then a limit of zero below the in-flight count
      set_window(255, 8);
      repeat (4) add_item(MODE_SEND, $urandom, SEQ_BITS'($urandom));
      set_window(255, 0);
      add_item(MODE_SEND, $urandom, '0);
      add_item(MODE_ACK, '0, gen.base + 16'd3);
      add_item(MODE_SEND, $urandom, '0);
      add_item(MODE_ACK, '0, gen.nxt);
      add_item(MODE_SEND, $urandom, '0);
      add_item(MODE_TICK, '0, '0);

      // Random phases across register settings and pacing
      random_phase(0, 8, 1'b1, 1'b1, 50, 1'b0);
      random_phase(255, 15, 1'b1, 1'b1, 45, 1'b0);
      random_phase(2, 1, 1'b0, 1'b0, 45, 1'b0);
      random_phase($urandom_range(1, 6), 3, 1'b0, 1'b1, 50, 1'b1);
      random_phase(5, 8, 1'b1, 1'b1, 50, 1'b0);
      random_phase($urandom_range(0, 4), $urandom_range(0, 15), 1'b1, 1'b1, 45, 1'b0);
      random_phase(1, 7, 1'b1, 1'b0, 45, 1'b0);

      wait_idle();
      $display("covered %0d request beats under %0d register settings", items_taken,
               settings_run);
      $display("checked %0d result beats: %0d resends, %0d refusals", beats_checked,
               retx_count, refused_count);
      if (err_count == 0) begin
         $display("go_back_n_sender_window_unit_tb: clean");
      end else begin
         $display("go_back_n_sender_window_unit_tb: errors");
      end
      $finish;
   end

endmodule
